// ----- rtl/core/stq_pkg.sv -----
// sorted timer queue: shared sizes, operation and result codes, entry type
// no dependencies
`default_nettype none

package stq_pkg;

	localparam int ENTRIES   = 16;
	localparam int TIME_BITS = 32;
	localparam int ID_BITS   = 16;
	localparam int ADDR_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_BITS  = $clog2(ENTRIES + 1);
	// at most this many expired timers per tick
	localparam int MAX_OUT   = (ENTRIES < 16) ? ENTRIES : 16;

	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_ADJUST = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;
	localparam logic [1:0] OP_TICK   = 2'd3;

	localparam logic [1:0] KIND_DONE    = 2'd0;
	localparam logic [1:0] KIND_EXPIRED = 2'd1;
	localparam logic [1:0] KIND_NONE    = 2'd2;
	localparam logic [1:0] KIND_ERROR   = 2'd3;

	typedef struct packed {
		logic [TIME_BITS-1:0] expiry;
		logic [ID_BITS-1:0]   ident;
	} entry_t;

endpackage

`default_nettype wire

// ----- rtl/core/sorted_timer_queue_top.sv -----
// sorted timer queue: entry memory, scan sequencer and output register
// depends on stq_pkg
`default_nettype none

//  channel | direction | handshake           | payload
//  in      | into      | in_valid, in_stall  | op, timer_id, expire_time, now_time
//  out     | out of    | out_valid, out_stall| kind, timer_id_res, last
//
// an accepted word is worked on until its walk ends: an operation walks the stored entries
// one per cycle while the output register is free, through the single read port
// of the entry memory, shifting entries through the write port behind the read.
// an add to a full queue and a tick with nothing due end without a walk, an adjust ends at its slot.
// in_stall is high from the cycle after an accept until the walk ends.
// reset clears the entry count and the output register; the memory keeps its contents.
// a full output register holds the walk in place until the word is taken.
module sorted_timer_queue_top (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire  [1:0]                   op,
	input  wire  [stq_pkg::ID_BITS-1:0]  timer_id,
	input  wire  [stq_pkg::TIME_BITS-1:0] expire_time,
	input  wire  [stq_pkg::TIME_BITS-1:0] now_time,
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic [1:0]                   kind,
	output logic [stq_pkg::ID_BITS-1:0]  timer_id_res,
	output logic                         last
);

	localparam int AW = stq_pkg::ADDR_BITS;
	localparam int CW = stq_pkg::CNT_BITS;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	stq_pkg::entry_t mem_q [stq_pkg::ENTRIES];
	stq_pkg::entry_t rd_q;

	logic                          state_q, state_d;
	logic [CW-1:0]                 cnt_q, cnt_d;
	logic [CW-1:0]                 idx_q, idx_d;
	logic [CW-1:0]                 n_q, n_d;
	logic                          hit_q, hit_d;
	logic                          mv_q, mv_d;
	stq_pkg::entry_t               carry_q, carry_d;
	logic [stq_pkg::ID_BITS-1:0]   pend_q, pend_d;
	logic [1:0]                    op_q;
	logic [stq_pkg::ID_BITS-1:0]   id_q;
	logic [stq_pkg::TIME_BITS-1:0] t_q;
	logic [stq_pkg::TIME_BITS-1:0] now_q;

	logic                          rd_en, wr_en;
	logic [AW-1:0]                 rd_addr, wr_addr;
	stq_pkg::entry_t               wr_data, new_e;
	logic                          push, push_last, out_free, at_end, due, accept;
	logic [1:0]                    push_kind;
	logic [stq_pkg::ID_BITS-1:0]   push_id;
	logic [CW-1:0]                 idx_inc, idx_m1, idx_mn;

	logic                          ov_q;
	logic [1:0]                    kind_q;
	logic [stq_pkg::ID_BITS-1:0]   rid_q;
	logic                          last_q;

	assign in_stall     = (state_q == ST_SCAN);
	assign accept       = in_valid && !in_stall;
	assign out_free     = !ov_q || !out_stall;
	assign out_valid    = ov_q;
	assign kind         = kind_q;
	assign timer_id_res = rid_q;
	assign last         = last_q;

	assign at_end  = (idx_q == cnt_q);
	assign idx_inc = idx_q + 1'b1;
	assign idx_m1  = idx_q - 1'b1;
	assign idx_mn  = idx_q - n_q;
	assign new_e   = '{expiry: t_q, ident: id_q};
	assign due     = !at_end && (rd_q.expiry <= now_q) && (n_q < CW'(stq_pkg::MAX_OUT));

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		idx_d     = idx_q;
		n_d       = n_q;
		hit_d     = hit_q;
		mv_d      = mv_q;
		carry_d   = carry_q;
		pend_d    = pend_q;
		rd_en     = 1'b0;
		rd_addr   = '0;
		wr_en     = 1'b0;
		wr_addr   = idx_q[AW-1:0];
		wr_data   = new_e;
		push      = 1'b0;
		push_kind = stq_pkg::KIND_DONE;
		push_id   = id_q;
		push_last = 1'b1;

		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_SCAN;
					idx_d   = '0;
					n_d     = '0;
					hit_d   = 1'b0;
					mv_d    = 1'b0;
					rd_en   = 1'b1;
				end
			end
			ST_SCAN: begin
				case (op_q)
					stq_pkg::OP_ADD: begin
						if (cnt_q == CW'(stq_pkg::ENTRIES)) begin
							push      = 1'b1;
							push_kind = stq_pkg::KIND_ERROR;
							state_d   = ST_IDLE;
						end else if (at_end) begin
							wr_en   = 1'b1;
							wr_data = hit_q ? carry_q : new_e;
							cnt_d   = cnt_q + 1'b1;
							push    = 1'b1;
							state_d = ST_IDLE;
						end else begin
							if (hit_q) begin
								wr_en   = 1'b1;
								wr_data = carry_q;
								carry_d = rd_q;
							end else if (rd_q.expiry > t_q) begin
								wr_en   = 1'b1;
								carry_d = rd_q;
								hit_d   = 1'b1;
							end
							idx_d   = idx_inc;
							rd_en   = (idx_inc < cnt_q);
							rd_addr = idx_inc[AW-1:0];
						end
					end
					stq_pkg::OP_DELETE: begin
						if (at_end) begin
							push      = 1'b1;
							push_kind = hit_q ? stq_pkg::KIND_DONE : stq_pkg::KIND_ERROR;
							if (hit_q)
								cnt_d = cnt_q - 1'b1;
							state_d   = ST_IDLE;
						end else begin
							if (hit_q) begin
								wr_en   = 1'b1;
								wr_addr = idx_m1[AW-1:0];
								wr_data = rd_q;
							end else if (rd_q.ident == id_q) begin
								hit_d = 1'b1;
							end
							idx_d   = idx_inc;
							rd_en   = (idx_inc < cnt_q);
							rd_addr = idx_inc[AW-1:0];
						end
					end
					stq_pkg::OP_ADJUST: begin
						wr_addr = idx_m1[AW-1:0];
						if (!hit_q) begin
							if (at_end) begin
								push      = 1'b1;
								push_kind = stq_pkg::KIND_ERROR;
								state_d   = ST_IDLE;
							end else begin
								hit_d   = (rd_q.ident == id_q);
								idx_d   = idx_inc;
								rd_en   = (idx_inc < cnt_q);
								rd_addr = idx_inc[AW-1:0];
							end
						end else if (!mv_q && (at_end || t_q < rd_q.expiry)) begin
							wr_en   = 1'b1;
							push    = 1'b1;
							state_d = ST_IDLE;
						end else if (mv_q && (at_end || rd_q.expiry > t_q)) begin
							wr_en   = 1'b1;
							push    = 1'b1;
							state_d = ST_IDLE;
						end else begin
							wr_en   = 1'b1;
							wr_data = rd_q;
							mv_d    = 1'b1;
							idx_d   = idx_inc;
							rd_en   = (idx_inc < cnt_q);
							rd_addr = idx_inc[AW-1:0];
						end
					end
					default: begin
						wr_addr   = idx_mn[AW-1:0];
						wr_data   = rd_q;
						push_kind = stq_pkg::KIND_EXPIRED;
						push_id   = pend_q;
						if (!hit_q && due) begin
							push      = (n_q != '0);
							push_last = 1'b0;
							pend_d    = rd_q.ident;
							n_d       = n_q + 1'b1;
							idx_d     = idx_inc;
							rd_en     = (idx_inc < cnt_q);
							rd_addr   = idx_inc[AW-1:0];
						end else if (!hit_q && n_q == '0) begin
							push      = 1'b1;
							push_kind = stq_pkg::KIND_NONE;
							push_id   = '0;
							state_d   = ST_IDLE;
						end else begin
							push = !hit_q;
							if (at_end) begin
								cnt_d   = cnt_q - n_q;
								state_d = ST_IDLE;
							end else begin
								wr_en   = 1'b1;
								hit_d   = 1'b1;
								idx_d   = idx_inc;
								rd_en   = (idx_inc < cnt_q);
								rd_addr = idx_inc[AW-1:0];
							end
						end
					end
				endcase

				// hold the walk while the output register is full
				if (push && !out_free) begin
					state_d = state_q;
					cnt_d   = cnt_q;
					idx_d   = idx_q;
					n_d     = n_q;
					hit_d   = hit_q;
					mv_d    = mv_q;
					carry_d = carry_q;
					pend_d  = pend_q;
					rd_en   = 1'b0;
					wr_en   = 1'b0;
					push    = 1'b0;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
		if (rd_en)
			rd_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		carry_q <= carry_d;
		pend_q  <= pend_d;
		if (accept) begin
			op_q  <= op;
			id_q  <= timer_id;
			t_q   <= expire_time;
			now_q <= now_time;
		end
		if (push) begin
			kind_q <= push_kind;
			rid_q  <= push_id;
			last_q <= push_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			idx_q   <= '0;
			n_q     <= '0;
			hit_q   <= 1'b0;
			mv_q    <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			idx_q   <= idx_d;
			n_q     <= n_d;
			hit_q   <= hit_d;
			mv_q    <= mv_d;
			if (push)
				ov_q <= 1'b1;
			else if (!out_stall)
				ov_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/stq_check.sv -----
// sorted timer queue: port-level checks and their bind to the top level
// depends on stq_pkg and sorted_timer_queue_top
`default_nettype none

module stq_check (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          in_valid,
	input wire                          in_stall,
	input wire [1:0]                    op,
	input wire [stq_pkg::ID_BITS-1:0]   timer_id,
	input wire [stq_pkg::TIME_BITS-1:0] expire_time,
	input wire [stq_pkg::TIME_BITS-1:0] now_time,
	input wire                          out_valid,
	input wire                          out_stall,
	input wire [1:0]                    kind,
	input wire [stq_pkg::ID_BITS-1:0]   timer_id_res,
	input wire                          last
);

	// stalled input word holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(op) && $stable(timer_id)
			&& $stable(expire_time) && $stable(now_time))
		else $error("input word changed while stalled");

	// stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) && $stable(timer_id_res)
			&& $stable(last))
		else $error("output word changed while stalled");

	// one word in flight: input closes right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after accept");

	// nothing-expired word is the only word of a tick
	a_none_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == stq_pkg::KIND_NONE |-> last && timer_id_res == '0)
		else $error("nothing-expired word malformed");

	// done and error words always close their operation
	a_single_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == stq_pkg::KIND_DONE || kind == stq_pkg::KIND_ERROR) |-> last)
		else $error("done or error word without last");

endmodule

bind sorted_timer_queue_top stq_check u_stq_check (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.op           (op),
	.timer_id     (timer_id),
	.expire_time  (expire_time),
	.now_time     (now_time),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.kind         (kind),
	.timer_id_res (timer_id_res),
	.last         (last)
);

`default_nettype wire
